FILE: src/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/sha1_pkg.sv
// types, codes and constants of the sha-1 byte stream hasher
// no dependencies; used by sha1_ctrl, sha1_dp and the top level
`default_nettype none

package sha1_pkg;

  localparam logic [1:0] ACT_ABSORB  = 2'd0;
  localparam logic [1:0] ACT_FINISH  = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_TOO_LONG     = 2'd1;
  localparam logic [1:0] ST_AFTER_FINISH = 2'd2;

  localparam logic [31:0] H_INIT0 = 32'h67452301;
  localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT3 = 32'h10325476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  // first byte position of the length field
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  typedef struct packed {
    logic       capture;
    logic [1:0] pend_status;
    logic       pend_valid;
    logic       absorb;
    logic       pad_shift;
    logic       pad_mark;
    logic       set_finished;
    logic       set_after_finish;
    logic       restart;
    logic       blk_start;
    logic       round;
    logic [1:0] rphase;
    logic       fold;
    logic       load_result;
  } sha1_cmd_t;

  typedef struct packed {
    logic       finished;
    logic [1:0] err;
    logic       fill_last;
    logic       pad_len;
  } sha1_sts_t;

  function automatic logic [31:0] round_const(input logic [1:0] phase);
    logic [31:0] k;
    case (phase)
      2'd0:    k = 32'h5A827999;
      2'd1:    k = 32'h6ED9EBA1;
      2'd2:    k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: src/sha1_byte_stream_hasher_unit.sv
// sha-1 byte stream hasher, top level: controller, datapath and checks
// depends on sha1_pkg, sha1_ctrl, sha1_dp and assert_macros.svh
//
// usage: the command channel (cmd_valid / cmd_stall) carries one action per
// beat: absorb a data byte, finish the message, or restart a new one. Every
// command beat gives exactly one beat on the result channel (res_valid /
// res_stall) with a status and, after a good finish, the 160-bit digest.
// One item at a time: an absorb that does not complete a 64-byte block goes
// from accept straight to its result; one that completes a block first runs
// 80 rounds through the single round unit, then the hash update. A finish
// with p bytes pending shifts its pad bytes one per cycle, pausing while a block
// is hashed (64 - p bytes, or 128 - p when p > 55), and runs one or two blocks.
// cmd_stall is high from accept until the result is registered.
// Reset (rst, synchronous) loads the initial hash values and clears counts
// and flags; no clearing pass is needed. A stalled result stays in the output
// register; the next command is taken meanwhile and its result waits for it.
`default_nettype none
`include "assert_macros.svh"

module sha1_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic        digest_valid,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);
  import sha1_pkg::*;

  sha1_cmd_t cmd;
  sha1_sts_t sts;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .action    (action),
    .cmd_stall (cmd_stall),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha1_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .digest_valid (digest_valid),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4)
  );

  // a result without a digest carries zero words
  `ASSERT_SAME_CYCLE(a_no_digest_zero, clk, rst, res_valid && !digest_valid, (digest_word0 == 32'd0) && (digest_word1 == 32'd0) && (digest_word2 == 32'd0) && (digest_word3 == 32'd0) && (digest_word4 == 32'd0))
  // a digest is only given with good status
  `ASSERT_SAME_CYCLE(a_digest_ok, clk, rst, res_valid && digest_valid, status == ST_OK)
  // one item in flight: the command side closes right after a beat
  `ASSERT_NEXT_CYCLE(a_one_in_flight, clk, rst, cmd_valid && !cmd_stall, cmd_stall)

endmodule

`default_nettype wire

FILE: src/sha1_ctrl.sv
// controller of the sha-1 hasher: item decode, padding, round and reply sequencing
// depends on sha1_pkg
`default_nettype none

module sha1_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic [1:0]           action,
  output logic                 cmd_stall,
  input  logic                 res_stall,
  output logic                 res_valid,
  input  sha1_pkg::sha1_sts_t  sts,
  output sha1_pkg::sha1_cmd_t  cmd
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_REPLY = 3'd4;

  logic [2:0] state, state_next;
  logic [6:0] rnd, rnd_next;
  logic       ret_pad, ret_pad_next;
  logic       res_valid_next;
  logic [1:0] phase;

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    if (rnd < 7'd20) begin
      phase = 2'd0;
    end else if (rnd < 7'd40) begin
      phase = 2'd1;
    end else if (rnd < 7'd60) begin
      phase = 2'd2;
    end else begin
      phase = 2'd3;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.rphase     = phase;
    state_next     = state;
    rnd_next       = rnd;
    ret_pad_next   = ret_pad;
    res_valid_next = res_valid && res_stall;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd.capture     = 1'b1;
          cmd.pend_status = sts.err;
          state_next      = S_REPLY;
          case (action)
            ACT_ABSORB: begin
              if (sts.finished) begin
                cmd.set_after_finish = 1'b1;
                cmd.pend_status      = ST_AFTER_FINISH;
              end else if (sts.err == ST_OK) begin
                cmd.absorb = 1'b1;
                if (sts.fill_last) begin
                  cmd.blk_start = 1'b1;
                  rnd_next      = '0;
                  ret_pad_next  = 1'b0;
                  state_next    = S_ROUND;
                end
              end
            end
            ACT_FINISH: begin
              if (sts.err == ST_OK) begin
                cmd.pend_valid = 1'b1;
                if (!sts.finished) begin
                  cmd.set_finished = 1'b1;
                  cmd.pad_shift    = 1'b1;
                  cmd.pad_mark     = 1'b1;
                  if (sts.fill_last) begin
                    cmd.blk_start = 1'b1;
                    rnd_next      = '0;
                    ret_pad_next  = 1'b1;
                    state_next    = S_ROUND;
                  end else begin
                    state_next = S_PAD;
                  end
                end
              end
            end
            ACT_RESTART: begin
              cmd.restart     = 1'b1;
              cmd.pend_status = ST_OK;
            end
            default: begin
            end
          endcase
        end
      end
      S_PAD: begin
        cmd.pad_shift = 1'b1;
        if (sts.fill_last) begin
          cmd.blk_start = 1'b1;
          rnd_next      = '0;
          // the block that ends in the length field is the last one
          ret_pad_next  = !sts.pad_len;
          state_next    = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (rnd == LAST_ROUND) begin
          state_next = S_FOLD;
        end else begin
          rnd_next = rnd + 7'd1;
        end
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ret_pad ? S_PAD : S_REPLY;
      end
      S_REPLY: begin
        if (!res_valid || !res_stall) begin
          cmd.load_result = 1'b1;
          res_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= '0;
      ret_pad   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      ret_pad   <= ret_pad_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/sha1_dp.sv
// datapath of the sha-1 hasher: block shift register, round unit, hash words,
// bit count, flags and the result register; depends on sha1_pkg
`default_nettype none

module sha1_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  sha1_pkg::sha1_cmd_t  cmd,
  output sha1_pkg::sha1_sts_t  sts,
  output logic [1:0]           status,
  output logic                 digest_valid,
  output logic [31:0]          digest_word0,
  output logic [31:0]          digest_word1,
  output logic [31:0]          digest_word2,
  output logic [31:0]          digest_word3,
  output logic [31:0]          digest_word4
);
  import sha1_pkg::*;

  logic [31:0]  hash [5];
  logic [31:0]  wa, wb, wc, wd, we;
  // message window, oldest word in the top bits
  logic [511:0] win;
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  logic         finished;
  logic [1:0]   err;
  logic         pad_wrap;
  logic [1:0]   pend_status;
  logic         pend_valid;

  logic         pad_len;
  logic         shift_en;
  logic [63:0]  len_sh;
  logic [7:0]   shift_byte;
  logic [64:0]  count_sum;
  logic [31:0]  w0, w2, w8, w13, w_mix, new_w;
  logic [31:0]  f_val, t_val;

  assign pad_len  = !pad_wrap && (fill >= LEN_POS);
  assign shift_en = cmd.absorb || cmd.pad_shift;
  // length field goes out most significant byte first
  assign len_sh   = bit_count << {fill[2:0], 3'b000};

  always_comb begin
    if (cmd.absorb) begin
      shift_byte = data_byte;
    end else if (cmd.pad_mark) begin
      shift_byte = PAD_MARK;
    end else if (pad_len) begin
      shift_byte = len_sh[63:56];
    end else begin
      shift_byte = 8'h00;
    end
  end

  assign count_sum = {1'b0, bit_count} + 65'd8;

  assign w0    = win[511:480];
  assign w2    = win[447:416];
  assign w8    = win[255:224];
  assign w13   = win[95:64];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign new_w = {w_mix[30:0], w_mix[31]};

  always_comb begin
    case (cmd.rphase)
      2'd0:    f_val = (wb & wc) | (~wb & wd);
      2'd2:    f_val = (wb & wc) | (wb & wd) | (wc & wd);
      default: f_val = wb ^ wc ^ wd;
    endcase
  end

  assign t_val = {wa[26:0], wa[31:27]} + f_val + we + w0 + round_const(cmd.rphase);

  assign sts.finished  = finished;
  assign sts.err       = err;
  assign sts.fill_last = (fill == FILL_LAST);
  assign sts.pad_len   = pad_len;

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      hash[0]   <= H_INIT0;
      hash[1]   <= H_INIT1;
      hash[2]   <= H_INIT2;
      hash[3]   <= H_INIT3;
      hash[4]   <= H_INIT4;
      fill      <= '0;
      bit_count <= '0;
      finished  <= 1'b0;
      err       <= ST_OK;
      pad_wrap  <= 1'b0;
    end else begin
      if (shift_en) begin
        fill <= fill + 6'd1;
        if (fill == FILL_LAST) begin
          pad_wrap <= 1'b0;
        end else if (cmd.pad_mark) begin
          // marker at or past the length field: zero-fill and add a block
          pad_wrap <= (fill >= LEN_POS);
        end
      end
      if (cmd.absorb) begin
        bit_count <= count_sum[63:0];
        if (count_sum[64]) begin
          err <= ST_TOO_LONG;
        end
      end
      if (cmd.set_after_finish) begin
        err <= ST_AFTER_FINISH;
      end
      if (cmd.set_finished) begin
        finished <= 1'b1;
      end
      if (cmd.fold) begin
        hash[0] <= hash[0] + wa;
        hash[1] <= hash[1] + wb;
        hash[2] <= hash[2] + wc;
        hash[3] <= hash[3] + wd;
        hash[4] <= hash[4] + we;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win <= {win[503:0], shift_byte};
    end else if (cmd.round) begin
      win <= {win[479:0], new_w};
    end
    if (cmd.blk_start) begin
      wa <= hash[0];
      wb <= hash[1];
      wc <= hash[2];
      wd <= hash[3];
      we <= hash[4];
    end else if (cmd.round) begin
      we <= wd;
      wd <= wc;
      wc <= {wb[1:0], wb[31:2]};
      wb <= wa;
      wa <= t_val;
    end
    if (cmd.capture) begin
      pend_status <= cmd.pend_status;
      pend_valid  <= cmd.pend_valid;
    end
    if (cmd.load_result) begin
      status       <= pend_status;
      digest_valid <= pend_valid;
      digest_word0 <= pend_valid ? hash[0] : 32'd0;
      digest_word1 <= pend_valid ? hash[1] : 32'd0;
      digest_word2 <= pend_valid ? hash[2] : 32'd0;
      digest_word3 <= pend_valid ? hash[3] : 32'd0;
      digest_word4 <= pend_valid ? hash[4] : 32'd0;
    end
  end

endmodule

`default_nettype wire
